// ===== hdl/ccrt_pkg.sv =====
// Package for the coupon-collector randomness test.
// Holds command and register codes, default sizes and shared types.
// No dependencies.
`default_nettype none

package ccrt_pkg;

    localparam int HIST_BINS_DEF   = 1024;
    localparam int MAX_COUPONS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int BIN_W    = 10;
    localparam int CCOUNT_W = 5;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 16;
    localparam int COUPON_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COUPON_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW     = 2'd2;

    localparam logic [CCOUNT_W-1:0] COUPON_COUNT_RST = 5'd2;
    localparam logic [WORD_W-1:0]   SEED_HIGH_RST    = 32'd0;
    localparam logic [WORD_W-1:0]   SEED_LOW_RST     = 32'd1;

    localparam logic [LEN_W-1:0]  LEN_MAX  = 16'hFFFF;
    localparam logic [WORD_W-1:0] TALLY_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                fresh;
        logic                done;
        logic [COUPON_W-1:0] coupon;
        logic [LEN_W-1:0]    tuple_length;
        logic [LEN_W-1:0]    longest_length;
    } draw_res_t;

    typedef struct packed {
        draw_res_t res;
        logic      rd_hist;
    } stage_t;

endpackage

`default_nettype wire

// ===== hdl/ccrt_draw.sv =====
// Generator and tuple tracker: 64-bit shift register, coupon mapping,
// seen flags, tuple length and longest length. Depends on ccrt_pkg.
`default_nettype none

module ccrt_draw
    import ccrt_pkg::*;
#(
    parameter int HIST_BINS   = HIST_BINS_DEF,
    parameter int MAX_COUPONS = MAX_COUPONS_DEF,
    localparam int ADDR_W = $clog2(HIST_BINS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [CCOUNT_W-1:0] coupon_count,
    input  wire logic [WORD_W-1:0]   seed_high,
    input  wire logic [WORD_W-1:0]   seed_low,
    output draw_res_t                res,
    output logic [ADDR_W-1:0]        slot
);

    localparam int N_W   = $clog2(MAX_COUPONS + 1);
    localparam int CPN_W = (MAX_COUPONS > 2) ? $clog2(MAX_COUPONS) : 1;

    logic [WORD_W-1:0]      shift_high_reg, shift_high_next;
    logic [WORD_W-1:0]      shift_low_reg, shift_low_next;
    logic [MAX_COUPONS-1:0] seen_reg, seen_next;
    logic [LEN_W-1:0]       draws_reg, draws_next;
    logic [LEN_W-1:0]       longest_reg, longest_next;

    logic                   fb;
    logic [WORD_W-1:0]      new_high, new_low;
    logic [N_W-1:0]         n_val;
    logic [WORD_W+N_W-1:0]  prod;
    logic [CPN_W-1:0]       coupon_idx;
    logic [MAX_COUPONS-1:0] coupon_bit, seen_or, n_mask;
    logic [LEN_W-1:0]       draws_inc, longest_upd;
    logic                   fresh, done;

    always_comb
    begin
        fb       = shift_low_reg[4] ^ shift_low_reg[3] ^ shift_low_reg[1] ^ shift_low_reg[0];
        new_high = {fb, shift_high_reg[WORD_W-1:1]};
        new_low  = {shift_high_reg[0], shift_low_reg[WORD_W-1:1]};

        if (coupon_count < CCOUNT_W'(2))
            n_val = N_W'(2);
        else if (32'(coupon_count) > 32'(MAX_COUPONS))
            n_val = N_W'(MAX_COUPONS);
        else
            n_val = N_W'(coupon_count);

        prod       = (WORD_W+N_W)'(new_low) * (WORD_W+N_W)'(n_val);
        coupon_idx = prod[WORD_W +: CPN_W];
        coupon_bit = MAX_COUPONS'(1) << coupon_idx;

        for (int i = 0; i < MAX_COUPONS; i++)
            n_mask[i] = (32'(n_val) > 32'(i));

        draws_inc = (draws_reg == LEN_MAX) ? draws_reg : draws_reg + LEN_W'(1);
        fresh     = ~|(seen_reg & coupon_bit);
        seen_or   = seen_reg | coupon_bit;
        done      = &(seen_or | ~n_mask);
        longest_upd = (done && (draws_inc > longest_reg)) ? draws_inc : longest_reg;

        if (32'(draws_inc) > 32'(HIST_BINS - 1))
            slot = ADDR_W'(HIST_BINS - 1);
        else
            slot = ADDR_W'(draws_inc);

        res = '0;
        shift_high_next = shift_high_reg;
        shift_low_next  = shift_low_reg;
        seen_next       = seen_reg;
        draws_next      = draws_reg;
        longest_next    = longest_reg;

        unique case (cmd)
            CMD_DRAW:
            begin
                res.fresh          = fresh;
                res.done           = done;
                res.coupon         = COUPON_W'(coupon_idx);
                res.tuple_length   = done ? draws_inc : '0;
                res.longest_length = longest_upd;
                shift_high_next    = new_high;
                shift_low_next     = new_low;
                seen_next          = done ? '0 : seen_or;
                draws_next         = done ? '0 : draws_inc;
                longest_next       = longest_upd;
            end
            CMD_RESTART:
            begin
                shift_high_next = seed_high;
                shift_low_next  = seed_low;
                seen_next       = '0;
                draws_next      = '0;
                longest_next    = '0;
            end
            CMD_READ, CMD_NOP:
            begin
                res.longest_length = longest_reg;
            end
            default:
            begin
                res.longest_length = longest_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_high_reg <= SEED_HIGH_RST;
            shift_low_reg  <= SEED_LOW_RST;
            seen_reg       <= '0;
            draws_reg      <= '0;
            longest_reg    <= '0;
        end
        else if (adv)
        begin
            shift_high_reg <= shift_high_next;
            shift_low_reg  <= shift_low_next;
            seen_reg       <= seen_next;
            draws_reg      <= draws_next;
            longest_reg    <= longest_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ccrt_hist.sv =====
// Length histogram: synchronous memory, read-increment-write with
// forwarding, and the clearing sweep. Depends on ccrt_pkg.
`default_nettype none

module ccrt_hist
    import ccrt_pkg::*;
#(
    parameter int HIST_BINS = HIST_BINS_DEF,
    localparam int ADDR_W = $clog2(HIST_BINS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              upd_en,
    input  wire logic [ADDR_W-1:0] upd_addr,
    input  wire logic              clr_start,
    output logic [WORD_W-1:0]      rd_data,
    output logic                   busy
);

    logic [WORD_W-1:0] mem [HIST_BINS];
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;
    logic              clr_reg, clr_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata, inc;

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign inc     = (rd_data == TALLY_MAX) ? rd_data : rd_data + WORD_W'(1);
    assign busy    = clr_reg;

    always_comb
    begin
        if (clr_reg)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else
        begin
            we    = upd_en;
            waddr = upd_addr;
            wdata = inc;
        end

        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(HIST_BINS - 1))
            begin
                clr_next     = 1'b0;
                clr_cnt_next = '0;
            end
        end
        else if (clr_start)
        begin
            clr_next     = 1'b1;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (rd_en)
                fwd_hit_reg <= we && !clr_reg && (waddr == rd_addr);
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/coupon_collector_rng_test.sv =====
// Top level of the coupon-collector randomness test: configuration
// registers, pipeline control and output register.
// Depends on ccrt_pkg, ccrt_draw and ccrt_hist.
//
//  channel  | direction | tdata (low bit up)                        | tuser / tlast
//  ---------+-----------+-------------------------------------------+---------------
//  s_axis   | in        | bin_index                                 | tuser: cmd
//  m_axis   | out       | coupon, fresh, tuple_length,              | tlast: tuple_done
//           |           | longest_length, tally_value               |
//  cfg      | in        | cfg_index selects register, cfg_data      | -
//
// One transaction per cycle unless busy or stalled; results go via b_reg, o_res_reg.
// Histogram read-increment-write is split over the accept and result cycles,
// with a forwarded count when consecutive draws hit the same bin.
// After reset and after each restart, a clearing sweep writes zero to all
// HIST_BINS bins, one per cycle; s_axis_tready stays low while the sweep runs.
// m_axis stalls back up through one stage buffer before s_axis_tready drops.
`default_nettype none

module coupon_collector_rng_test
    import ccrt_pkg::*;
#(
    parameter int HIST_BINS   = HIST_BINS_DEF,
    parameter int MAX_COUPONS = MAX_COUPONS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // bin_index
    input  wire logic [CMD_W-1:0]     s_axis_tuser,   // cmd
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [71:0]               m_axis_tdata,   // coupon, fresh, tuple_length,
                                                      // longest_length, tally_value
    output logic                      m_axis_tlast,   // tuple_done
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(HIST_BINS);

    logic [CCOUNT_W-1:0] coupon_count_reg;
    logic [WORD_W-1:0]   seed_high_reg, seed_low_reg;

    logic                b_valid_reg, b_valid_next;
    stage_t              b_reg;
    logic [ADDR_W-1:0]   b_addr_reg;
    logic                o_valid_reg, o_valid_next;
    draw_res_t           o_res_reg;
    logic [WORD_W-1:0]   o_tally_reg;

    logic [CMD_W-1:0]    cmd;
    logic [BIN_W-1:0]    bin_index;
    logic                accept, b_adv, busy, bin_ok, rd_en;
    draw_res_t           a_res;
    logic [ADDR_W-1:0]   slot, rd_addr;
    logic [WORD_W-1:0]   rd_data;

    assign cmd       = s_axis_tuser;
    assign bin_index = s_axis_tdata[BIN_W-1:0];

    assign b_adv         = b_valid_reg && (!o_valid_reg || m_axis_tready);
    assign s_axis_tready = !busy && (!b_valid_reg || b_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign bin_ok  = 32'(bin_index) < 32'(HIST_BINS);
    assign rd_addr = (cmd == CMD_DRAW) ? slot : ADDR_W'(bin_index);
    assign rd_en   = accept && (((cmd == CMD_DRAW) && a_res.done) ||
                                ((cmd == CMD_READ) && bin_ok));

    assign b_valid_next = accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
    assign o_valid_next = b_adv ? 1'b1 : (m_axis_tready ? 1'b0 : o_valid_reg);

    ccrt_draw #(
        .HIST_BINS   (HIST_BINS),
        .MAX_COUPONS (MAX_COUPONS)
    ) u_draw (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (accept),
        .cmd          (cmd),
        .coupon_count (coupon_count_reg),
        .seed_high    (seed_high_reg),
        .seed_low     (seed_low_reg),
        .res          (a_res),
        .slot         (slot)
    );

    ccrt_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .upd_en    (b_adv && b_reg.res.done),
        .upd_addr  (b_addr_reg),
        .clr_start (accept && (cmd == CMD_RESTART)),
        .rd_data   (rd_data),
        .busy      (busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupon_count_reg <= COUPON_COUNT_RST;
            seed_high_reg    <= SEED_HIGH_RST;
            seed_low_reg     <= SEED_LOW_RST;
            b_valid_reg      <= 1'b0;
            o_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COUPON_COUNT: coupon_count_reg <= cfg_data[CCOUNT_W-1:0];
                    REG_SEED_HIGH:    seed_high_reg    <= cfg_data;
                    REG_SEED_LOW:     seed_low_reg     <= cfg_data;
                    default:          ;
                endcase
            end
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg.res     <= a_res;
            b_reg.rd_hist <= (cmd == CMD_READ) && bin_ok;
            b_addr_reg    <= rd_addr;
        end
        if (b_adv)
        begin
            o_res_reg   <= b_reg.res;
            o_tally_reg <= b_reg.rd_hist ? rd_data : '0;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tlast  = o_res_reg.done;
    assign m_axis_tdata  = {3'b000, o_tally_reg, o_res_reg.longest_length,
                            o_res_reg.tuple_length, o_res_reg.fresh, o_res_reg.coupon};

endmodule

`default_nettype wire

// ===== tb/sv/tb_coupon_collector_rng_test.sv =====
// Self-checking testbench for coupon_collector_rng_test: a directed table of
// commands followed by random draw/read/restart/nop phases at several settings.
// Depends on ccrt_pkg and the coupon_collector_rng_test RTL.
module tb_coupon_collector_rng_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ccrt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_LIMIT   = 6000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int PRINT_CAP    = 50;
    localparam int HIST_BINS    = HIST_BINS_DEF;
    localparam int MAX_COUPONS  = MAX_COUPONS_DEF;

    localparam int FRESH_AT = COUPON_W;
    localparam int LEN_AT   = COUPON_W + 1;
    localparam int LONG_AT  = LEN_AT + LEN_W;
    localparam int TALLY_AT = LONG_AT + LEN_W;

    typedef struct packed {
        logic [COUPON_W-1:0] coupon;
        logic                fresh;
        logic                done;
        logic [LEN_W-1:0]    tuple_len;
        logic [LEN_W-1:0]    longest;
        logic [WORD_W-1:0]   tally;
    } result_t;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    reg_val;
        logic [CMD_W-1:0]     op;
        logic [BIN_W-1:0]     bin;
        logic                 fixed;
        result_t              want;
    } stim_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;   // bin_index
    logic [CMD_W-1:0]     s_axis_tuser  = CMD_NOP;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [71:0]          m_axis_tdata;   // coupon, fresh, tuple_length, longest_length, tally_value
    logic                 m_axis_tlast;   // tuple_done
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_COUPON_COUNT;
    logic [WORD_W-1:0]    cfg_data      = '0;

    // predictor copy of registers and test state
    logic [CCOUNT_W-1:0]    coupons_cfg = COUPON_COUNT_RST;
    logic [WORD_W-1:0]      seed_hi_cfg = SEED_HIGH_RST;
    logic [WORD_W-1:0]      seed_lo_cfg = SEED_LOW_RST;
    logic [WORD_W-1:0]      lfsr_hi;
    logic [WORD_W-1:0]      lfsr_lo;
    logic [MAX_COUPONS-1:0] seen;
    logic [LEN_W-1:0]       draws;
    logic [LEN_W-1:0]       longest;
    logic [WORD_W-1:0]      hist [HIST_BINS];

    result_t   pending_results [$];
    stim_row_t directed [$];
    int        error_count  = 0;
    int        quiet_cycles = 0;
    int        hold_left    = 0;
    int        stall_left   = 0;
    logic      hold_req     = 1'b0;
    logic      steady       = 1'b0;

    coupon_collector_rng_test DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_test();
        lfsr_hi = seed_hi_cfg;
        lfsr_lo = seed_lo_cfg;
        seen    = '0;
        draws   = '0;
        longest = '0;
        for (int i = 0; i < HIST_BINS; i++)
        begin
            hist[i] = '0;
        end
    endfunction

    function automatic result_t coupon_step(input logic [CMD_W-1:0] op,
                                            input logic [BIN_W-1:0] bin);
        result_t                r;
        logic [CCOUNT_W-1:0]    n;
        logic                   fb;
        logic                   carry;
        logic [63:0]            prod;
        logic [MAX_COUPONS:0]   span;
        logic [MAX_COUPONS-1:0] mask;
        logic [BIN_W-1:0]       slot;
        r = '0;
        case (op)
            CMD_DRAW:
            begin
                n = coupons_cfg;
                if (n < CCOUNT_W'(2))
                    n = CCOUNT_W'(2);
                else if (n > CCOUNT_W'(MAX_COUPONS))
                    n = CCOUNT_W'(MAX_COUPONS);
                fb      = lfsr_lo[4] ^ lfsr_lo[3] ^ lfsr_lo[1] ^ lfsr_lo[0];
                carry   = lfsr_hi[0];
                lfsr_hi = {fb, lfsr_hi[WORD_W-1:1]};
                lfsr_lo = {carry, lfsr_lo[WORD_W-1:1]};
                prod     = 64'(lfsr_lo) * 64'(n);
                r.coupon = prod[32 +: COUPON_W];
                if (draws != LEN_MAX)
                    draws = draws + 1'b1;
                if (!seen[r.coupon])
                begin
                    seen[r.coupon] = 1'b1;
                    r.fresh        = 1'b1;
                end
                span = ({{MAX_COUPONS{1'b0}}, 1'b1} << n) - 1'b1;
                mask = span[MAX_COUPONS-1:0];
                if ((seen & mask) == mask)
                begin
                    r.done      = 1'b1;
                    r.tuple_len = draws;
                    if (draws > longest)
                        longest = draws;
                    if (draws > LEN_W'(HIST_BINS - 1))
                        slot = BIN_W'(HIST_BINS - 1);
                    else
                        slot = draws[BIN_W-1:0];
                    if (hist[slot] != TALLY_MAX)
                        hist[slot] = hist[slot] + 1'b1;
                    seen  = '0;
                    draws = '0;
                end
            end
            CMD_READ:    r.tally = hist[bin];
            CMD_RESTART: clear_test();
            default:     ;
        endcase
        r.longest = longest;
        return r;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t ns mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // one input transaction; valid stays high if the next one follows at once
    task automatic send_item(input int gap, input logic [CMD_W-1:0] op,
                             input logic [BIN_W-1:0] bin, input logic fixed,
                             input result_t want);
        result_t pred;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(16 - BIN_W){1'b0}}, bin};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = coupon_step(op, bin);
        pending_results.push_back(fixed ? want : pred);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_COUPON_COUNT: coupons_cfg = val[CCOUNT_W-1:0];
            REG_SEED_HIGH:    seed_hi_cfg = val;
            REG_SEED_LOW:     seed_lo_cfg = val;
            default:          ;
        endcase
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        stim_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed.push_back(row);
    endtask

    task automatic add_item(input logic [CMD_W-1:0] op, input logic [BIN_W-1:0] bin);
        stim_row_t row;
        row     = '{default: '0};
        row.op  = op;
        row.bin = bin;
        directed.push_back(row);
    endtask

    // rows whose result is obvious: everything zero except coupon and fresh
    task automatic add_fixed(input logic [CMD_W-1:0] op, input logic [BIN_W-1:0] bin,
                             input logic [COUPON_W-1:0] coupon, input logic fresh);
        stim_row_t row;
        row             = '{default: '0};
        row.op          = op;
        row.bin         = bin;
        row.fixed       = 1'b1;
        row.want.coupon = coupon;
        row.want.fresh  = fresh;
        directed.push_back(row);
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: stall_left = $urandom_range(0, 2);
                6:                stall_left = $urandom_range(15, 60);
                default:          stall_left = -1;
            endcase
            m_axis_tready <= (stall_left < 0);
            if (stall_left < 0)
                stall_left = 0;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.coupon    = m_axis_tdata[0 +: COUPON_W];
            got.fresh     = m_axis_tdata[FRESH_AT];
            got.done      = m_axis_tlast;
            got.tuple_len = m_axis_tdata[LEN_AT +: LEN_W];
            got.longest   = m_axis_tdata[LONG_AT +: LEN_W];
            got.tally     = m_axis_tdata[TALLY_AT +: WORD_W];
            if (pending_results.size() == 0)
                flag_mismatch("unexpected transaction", got.tally, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.coupon !== want.coupon)
                    flag_mismatch("coupon", WORD_W'(got.coupon), WORD_W'(want.coupon));
                if (got.fresh !== want.fresh)
                    flag_mismatch("fresh", WORD_W'(got.fresh), WORD_W'(want.fresh));
                if (got.done !== want.done)
                    flag_mismatch("tuple_done", WORD_W'(got.done), WORD_W'(want.done));
                if (got.tuple_len !== want.tuple_len)
                    flag_mismatch("tuple_length", WORD_W'(got.tuple_len),
                                  WORD_W'(want.tuple_len));
                if (got.longest !== want.longest)
                    flag_mismatch("longest_length", WORD_W'(got.longest),
                                  WORD_W'(want.longest));
                if (got.tally !== want.tally)
                    flag_mismatch("tally_value", got.tally, want.tally);
            end
        end
    end

    // idle watchdog; its limit covers the clearing sweep after reset and restart
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t        row;
        int               count;
        int               draw_pct;
        int               r;
        logic             start_over;
        logic [CMD_W-1:0] op;
        logic [BIN_W-1:0] bin;

        clear_test();

        // defaults after reset: n = 2, seed 0/1
        add_fixed(CMD_NOP, '1, 4'd0, 1'b0);
        add_fixed(CMD_READ, '0, 4'd0, 1'b0);
        add_fixed(CMD_READ, '1, 4'd0, 1'b0);
        add_fixed(CMD_DRAW, '0, 4'd0, 1'b1);
        add_fixed(CMD_DRAW, '0, 4'd0, 1'b0);
        add_item(CMD_DRAW, '0);
        add_item(CMD_DRAW, '1);
        // count below range, all-ones seed
        add_cfg(REG_COUPON_COUNT, 32'd0);
        add_cfg(REG_SEED_HIGH, '1);
        add_cfg(REG_SEED_LOW, '1);
        add_fixed(CMD_RESTART, '0, 4'd0, 1'b0);
        add_item(CMD_DRAW, '0);
        add_item(CMD_DRAW, '0);
        add_item(CMD_DRAW, '0);
        // count above range
        add_cfg(REG_COUPON_COUNT, 32'd31);
        add_fixed(CMD_RESTART, '1, 4'd0, 1'b0);
        add_item(CMD_DRAW, '0);
        add_item(CMD_DRAW, '0);
        add_item(CMD_DRAW, '0);
        add_item(CMD_DRAW, '0);
        add_fixed(CMD_READ, '1, 4'd0, 1'b0);
        // all-zero register: coupon 0 forever
        add_cfg(REG_SEED_HIGH, '0);
        add_cfg(REG_SEED_LOW, '0);
        add_fixed(CMD_RESTART, '0, 4'd0, 1'b0);
        add_fixed(CMD_DRAW, '0, 4'd0, 1'b1);
        add_fixed(CMD_DRAW, '0, 4'd0, 1'b0);
        add_fixed(CMD_NOP, '0, 4'd0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            row = directed[i];
            if (row.is_cfg)
                write_reg(row.reg_idx, row.reg_val);
            else
                send_item(sender_gap(), row.op, row.bin, row.fixed, row.want);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            steady     = (phase == 1) || ($urandom_range(0, 3) == 0);
            start_over = 1'b1;
            draw_pct   = 80;
            case (phase)
                0:
                begin
                    write_reg(REG_COUPON_COUNT, 32'd2);
                    write_reg(REG_SEED_HIGH, $urandom());
                    write_reg(REG_SEED_LOW, $urandom());
                    count = 80;
                end
                1:
                begin
                    // sparse seed: long tuples with sixteen coupons
                    write_reg(REG_COUPON_COUNT, 32'd16);
                    write_reg(REG_SEED_HIGH, 32'd0);
                    write_reg(REG_SEED_LOW, 32'd1);
                    count    = 150;
                    draw_pct = 90;
                end
                2:
                begin
                    // count change mid-tuple
                    write_reg(REG_COUPON_COUNT, $urandom_range(3, 15));
                    start_over = 1'b0;
                    count      = 60;
                end
                3:
                begin
                    write_reg(REG_COUPON_COUNT, $urandom_range(2, 16));
                    write_reg(REG_SEED_HIGH, $urandom());
                    write_reg(REG_SEED_LOW, $urandom());
                    count = 80;
                end
                4:
                begin
                    write_reg(REG_COUPON_COUNT, 32'd1);
                    start_over = 1'b0;
                    count      = 50;
                end
                default:
                begin
                    write_reg(REG_COUPON_COUNT, $urandom_range(17, 31));
                    write_reg(REG_SEED_HIGH, '1);
                    write_reg(REG_SEED_LOW, $urandom());
                    count = 80;
                end
            endcase
            if (start_over)
                send_item(sender_gap(), CMD_RESTART, BIN_W'($urandom()), 1'b0, '0);
            for (int k = 0; k < count; k++)
            begin
                if (phase == 1 && k == 30)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < draw_pct)
                    op = CMD_DRAW;
                else if (r < draw_pct + 2)
                    op = CMD_RESTART;
                else if (r < draw_pct + 6)
                    op = CMD_NOP;
                else
                    op = CMD_READ;
                if ($urandom_range(0, 1) == 0)
                    bin = BIN_W'($urandom_range(1, 80));
                else
                    bin = BIN_W'($urandom_range(0, HIST_BINS - 1));
                send_item(sender_gap(), op, bin, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
